>>> sv/mon_pkg.sv
package mon_pkg;

  localparam int SUM_BITS       = 42;
  localparam int IDX_BITS       = 10;
  localparam int CNT_BITS       = 11;
  localparam int MODE_BITS      = 2;
  localparam int CFG_IDX_BITS   = 2;
  localparam int CFG_DATA_BITS  = 11;
  localparam int DEF_MAX_DIM    = 1024;
  localparam int DEF_VALUE_BITS = 32;

  localparam logic [SUM_BITS-1:0] SUM_MAX = '1;

  // mode register codes
  localparam logic [MODE_BITS-1:0] MODE_GENERAL = 2'd0;
  localparam logic [MODE_BITS-1:0] MODE_UPPER   = 2'd1;
  localparam logic [MODE_BITS-1:0] MODE_LOWER   = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_BITS-1:0] CFG_MODE         = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_ROW_COUNT    = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_COLUMN_COUNT = 2'd2;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_ACC,
    ST_SCAN,
    ST_DONE
  } state_t;

endpackage

>>> sv/mon_if.sv
interface mon_in_if import mon_pkg::*; #(
  parameter int VALUE_BITS = DEF_VALUE_BITS
) ();
  logic                         valid;
  logic                         ready;
  logic signed [VALUE_BITS-1:0] value;
  logic [IDX_BITS-1:0]          row;
  logic [IDX_BITS-1:0]          column;
  logic                         last;

  modport source (output valid, value, row, column, last, input ready);
  modport sink   (input valid, value, row, column, last, output ready);
endinterface

interface mon_out_if import mon_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [SUM_BITS-1:0] norm;
  logic                error;

  modport source (output valid, norm, error, input ready);
  modport sink   (input valid, norm, error, output ready);
endinterface

>>> sv/mon_sum_ram.sv
module mon_sum_ram import mon_pkg::*; #(
  parameter int DEPTH     = DEF_MAX_DIM,
  parameter int ADDR_BITS = $clog2(DEF_MAX_DIM),
  parameter int DATA_BITS = SUM_BITS
) (
  input  logic                 clk,
  input  logic                 wr_en,
  input  logic [ADDR_BITS-1:0] wr_addr,
  input  logic [DATA_BITS-1:0] wr_data,
  input  logic [ADDR_BITS-1:0] rd_addr,
  output logic [DATA_BITS-1:0] rd_data
);

  logic [DATA_BITS-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

>>> sv/matrix_one_norm.sv
// Streaming matrix one-norm. Elements arrive on in_ch with row and column index; their absolute
// values accumulate into a column-sum memory of MAX_DIM entries through a read-modify-write path
// with one-deep write forwarding. An element takes one pass through the update path, two in a
// Hermitian mode when it is an off-diagonal element of the stored triangle that is used, since its
// column and its mirrored row go through the single write port one after the other. After the
// transfer marked last the block sweeps the whole memory, one entry a cycle, taking the maximum
// over the scanned columns and clearing each entry as it goes, and then offers the result on
// out_ch. After reset the same sweep clears the memory: no element is accepted until it is done.
// The user must write configuration through cfg_* only while the block is idle; the block
// itself does not enforce it.
module matrix_one_norm import mon_pkg::*; #(
  parameter int MAX_DIM    = DEF_MAX_DIM,
  parameter int VALUE_BITS = DEF_VALUE_BITS
) (
  input  logic                     clk,
  input  logic                     rst_n,
  mon_in_if.sink                   in_ch,
  mon_out_if.source                out_ch,
  input  logic                     cfg_wr_en,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_data
);

  localparam int AW       = $clog2(MAX_DIM);
  localparam int ADD_BITS = ((SUM_BITS > VALUE_BITS) ? SUM_BITS : VALUE_BITS) + 1;
  localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_DIM - 1);

  logic [MODE_BITS-1:0]  mode_r;
  logic [CNT_BITS-1:0]   row_count_r;
  logic [CNT_BITS-1:0]   column_count_r;

  state_t                state_r, state_nxt;
  logic [AW-1:0]         cnt_r, cnt_nxt;

  logic                  s1_valid_r, s1_valid_nxt;
  logic                  s1_wr_r, s1_wr_nxt;
  logic                  s1_last_r, s1_last_nxt;
  logic [AW-1:0]         s1_addr_r, s1_addr_nxt;
  logic [VALUE_BITS-1:0] s1_mag_r;

  logic                  pend_r, pend_nxt;
  logic                  pend_last_r, pend_last_nxt;
  logic [AW-1:0]         pend_addr_r, pend_addr_nxt;

  logic                  fwd_valid_r;
  logic [AW-1:0]         fwd_addr_r;
  logic [SUM_BITS-1:0]   fwd_data_r;

  logic                  cmp_valid_r;
  logic [AW-1:0]         cmp_idx_r;
  logic [SUM_BITS-1:0]   max_r;

  logic                  out_valid_r;
  logic [SUM_BITS-1:0]   out_norm_r;
  logic                  out_error_r;

  logic                  in_ready;
  logic                  accept;
  logic                  herm;
  logic                  row_ok, col_ok, diag, stored, mirror_ok;
  logic                  op_a, op_b;
  logic [VALUE_BITS-1:0] mag;
  logic [SUM_BITS-1:0]   rd_data;
  logic [SUM_BITS-1:0]   old_sum;
  logic [ADD_BITS-1:0]   sum_wide;
  logic [SUM_BITS-1:0]   new_sum;
  logic                  s1_we;
  logic                  sweeping;
  logic                  mem_wr_en;
  logic [AW-1:0]         mem_wr_addr;
  logic [SUM_BITS-1:0]   mem_wr_data;
  logic [AW-1:0]         mem_rd_addr;
  logic [CNT_BITS-1:0]   scan_count;
  logic                  in_scan;
  logic                  load_out;
  logic                  norm_error;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r         <= MODE_GENERAL;
      row_count_r    <= CNT_BITS'(1);
      column_count_r <= CNT_BITS'(1);
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_MODE:         mode_r         <= cfg_data[MODE_BITS-1:0];
        CFG_ROW_COUNT:    row_count_r    <= cfg_data;
        CFG_COLUMN_COUNT: column_count_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // element decode
  assign herm   = (mode_r == MODE_UPPER) || (mode_r == MODE_LOWER);
  assign row_ok = (32'(in_ch.row) < 32'(row_count_r)) && (32'(in_ch.row) < MAX_DIM);
  assign col_ok = (32'(in_ch.column) < 32'(column_count_r)) && (32'(in_ch.column) < MAX_DIM);
  assign diag   = (in_ch.row == in_ch.column);
  assign stored = (mode_r == MODE_UPPER) ? (in_ch.row < in_ch.column)
                                         : (in_ch.row > in_ch.column);
  assign mirror_ok = (32'(in_ch.column) < 32'(row_count_r))
                  && (32'(in_ch.row) < 32'(column_count_r));
  assign op_a = row_ok && col_ok && (!herm || diag || (stored && mirror_ok));
  assign op_b = row_ok && col_ok && herm && !diag && stored && mirror_ok;
  assign mag  = in_ch.value[VALUE_BITS-1] ? (~in_ch.value + 1'b1) : in_ch.value;

  assign accept = in_ch.valid && in_ready;

  // micro-op issue: column update first, mirrored row update in the next cycle
  always_comb begin
    s1_valid_nxt  = 1'b0;
    s1_wr_nxt     = 1'b0;
    s1_last_nxt   = 1'b0;
    s1_addr_nxt   = s1_addr_r;
    pend_nxt      = 1'b0;
    pend_last_nxt = pend_last_r;
    pend_addr_nxt = pend_addr_r;
    if (pend_r) begin
      s1_valid_nxt = 1'b1;
      s1_wr_nxt    = 1'b1;
      s1_last_nxt  = pend_last_r;
      s1_addr_nxt  = pend_addr_r;
    end else if (accept) begin
      s1_valid_nxt  = 1'b1;
      s1_wr_nxt     = op_a;
      s1_last_nxt   = in_ch.last && !op_b;
      s1_addr_nxt   = AW'(in_ch.column);
      pend_nxt      = op_b;
      pend_last_nxt = in_ch.last;
      pend_addr_nxt = AW'(in_ch.row);
    end
  end

  // read-modify-write with forwarding of the previous cycle's write
  assign old_sum  = (fwd_valid_r && (fwd_addr_r == s1_addr_r)) ? fwd_data_r : rd_data;
  assign sum_wide = ADD_BITS'(old_sum) + ADD_BITS'(s1_mag_r);
  assign new_sum  = (sum_wide > ADD_BITS'(SUM_MAX)) ? SUM_MAX : sum_wide[SUM_BITS-1:0];
  assign s1_we    = s1_valid_r && s1_wr_r;

  assign sweeping    = (state_r == ST_CLEAR) || (state_r == ST_SCAN);
  assign mem_wr_en   = sweeping || s1_we;
  assign mem_wr_addr = sweeping ? cnt_r : s1_addr_r;
  assign mem_wr_data = sweeping ? '0 : new_sum;
  assign mem_rd_addr = (state_r == ST_SCAN) ? cnt_r : s1_addr_nxt;

  mon_sum_ram #(
    .DEPTH     (MAX_DIM),
    .ADDR_BITS (AW),
    .DATA_BITS (SUM_BITS)
  ) u_sum_ram (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_addr (mem_rd_addr),
    .rd_data (rd_data)
  );

  // scan
  assign scan_count = herm ? row_count_r : column_count_r;
  assign in_scan    = 32'(cmp_idx_r) < 32'(scan_count);
  assign norm_error = herm && (row_count_r != column_count_r);
  assign cnt_nxt    = (sweeping && (cnt_r != LAST_ADDR)) ? cnt_r + 1'b1 : '0;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: if (cnt_r == LAST_ADDR) state_nxt = ST_ACC;
      ST_ACC:   if (s1_valid_r && s1_last_r) state_nxt = ST_SCAN;
      ST_SCAN:  if (cnt_r == LAST_ADDR) state_nxt = ST_DONE;
      ST_DONE:  if (!cmp_valid_r && (!out_valid_r || out_ch.ready)) state_nxt = ST_ACC;
      default:  state_nxt = ST_CLEAR;
    endcase
  end

  // state outputs
  always_comb begin
    in_ready = 1'b0;
    load_out = 1'b0;
    unique case (state_r)
      ST_ACC:  in_ready = !pend_r && !(s1_valid_r && s1_last_r);
      ST_DONE: load_out = !cmp_valid_r && (!out_valid_r || out_ch.ready);
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      cnt_r       <= '0;
      s1_valid_r  <= 1'b0;
      pend_r      <= 1'b0;
      fwd_valid_r <= 1'b0;
      cmp_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      s1_valid_r  <= s1_valid_nxt;
      pend_r      <= pend_nxt;
      fwd_valid_r <= s1_we;
      cmp_valid_r <= (state_r == ST_SCAN);
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    s1_wr_r     <= s1_wr_nxt;
    s1_last_r   <= s1_last_nxt;
    s1_addr_r   <= s1_addr_nxt;
    pend_last_r <= pend_last_nxt;
    pend_addr_r <= pend_addr_nxt;
    fwd_addr_r  <= s1_addr_r;
    fwd_data_r  <= new_sum;
    cmp_idx_r   <= cnt_r;
    if (accept) begin
      s1_mag_r <= mag;
    end
    if (state_r == ST_ACC) begin
      max_r <= '0;
    end else if (cmp_valid_r && in_scan && (rd_data > max_r)) begin
      max_r <= rd_data;
    end
    if (load_out) begin
      out_norm_r  <= norm_error ? '0 : max_r;
      out_error_r <= norm_error;
    end
  end

  assign in_ch.ready  = in_ready;
  assign out_ch.valid = out_valid_r;
  assign out_ch.norm  = out_norm_r;
  assign out_ch.error = out_error_r;

endmodule
